/* rtl/dsur_pkg.sv */
// Shared types and constants for the blower duty/standby rotation block.
// Used by dsur_cell and duty_standby_unit_rotation_top.
`default_nettype none

package dsur_pkg;

    localparam int unsigned MAX_UNITS_DEF = 8;
    localparam int unsigned MAX_UNITS_LIM = 16;
    localparam int unsigned IDX_W         = $clog2(MAX_UNITS_LIM);
    localparam int unsigned CNT_W         = IDX_W + 1;
    localparam int unsigned RT_W          = 40;
    localparam int unsigned EL_W          = 16;
    localparam int unsigned MASK_W        = 8;
    localparam int unsigned MASK_IDX_W    = $clog2(MASK_W);
    localparam int unsigned OP_W          = 2;
    localparam int unsigned UCNT_W        = 4;
    localparam int unsigned AIDX_W        = 3;
    localparam int unsigned CFG_IDX_W     = 8;
    localparam int unsigned CFG_DATA_W    = 8;
    localparam int unsigned S_DATA_W      = 24;
    localparam int unsigned M_DATA_W      = 8;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROTATION_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_COUNT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MASK     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_MASK    = 8'd3;

    localparam logic [UCNT_W-1:0] UNIT_COUNT_RST = 4'd2;
    localparam logic [MASK_W-1:0] DUTY_MASK_RST  = 8'h01;
    localparam logic [MASK_W-1:0] FAULT_MASK_RST = 8'h00;

    // Selection packet passed down the row of unit cells.
    typedef struct packed {
        logic             duty_found;
        logic [IDX_W-1:0] duty_idx;
        logic [RT_W-1:0]  duty_min;
        logic             hi_found;
        logic [IDX_W-1:0] hi_idx;
        logic             lo_found;
        logic [IDX_W-1:0] lo_idx;
        logic             sb_found;
        logic [IDX_W-1:0] sb_idx;
    } scan_t;

    // Station configuration seen by every cell.
    typedef struct packed {
        logic [CNT_W-1:0]  n_units;
        logic [MASK_W-1:0] duty_mask;
        logic [MASK_W-1:0] fault_mask;
        logic [CNT_W-1:0]  rot_start;
    } cell_cfg_t;

    // Per-beat command broadcast to the cells.
    typedef struct packed {
        logic             tick;
        logic             set_run;
        logic             clr_run;
        logic [IDX_W-1:0] sel;
        logic [EL_W-1:0]  elapsed;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/dsur_cell.sv */
// One blower unit: run-time counter, run flag and one stage of the selection chain.
// Depends on dsur_pkg.
`default_nettype none

module dsur_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [dsur_pkg::IDX_W-1:0] idx,
    input  wire dsur_pkg::cell_cfg_t cfg,
    input  wire dsur_pkg::cell_cmd_t cmd,
    input  wire dsur_pkg::scan_t    scan_in,
    output dsur_pkg::scan_t         scan_out,
    output logic                    running
);
    import dsur_pkg::*;

    logic [RT_W-1:0] run_time_reg;
    logic [RT_W-1:0] run_time_next;
    logic            running_reg;
    logic            running_next;
    scan_t           scan_reg;
    scan_t           scan_next;
    logic [RT_W:0]   sum;
    logic            sel_me;
    logic            in_mask;
    logic            present;
    logic            duty;
    logic            fault;
    logic            hd;
    logic            hs;
    logic            after_start;

    assign sel_me  = (cmd.sel == idx);
    assign in_mask = (idx < IDX_W'(MASK_W));
    assign present = ({1'b0, idx} < cfg.n_units);
    assign duty    = in_mask && cfg.duty_mask[idx[MASK_IDX_W-1:0]];
    assign fault   = in_mask && cfg.fault_mask[idx[MASK_IDX_W-1:0]];
    assign hd      = present && duty && !fault;
    assign hs      = present && !duty && !fault;
    assign after_start = ({1'b0, idx} >= cfg.rot_start);

    // carry out of the 40-bit add means saturation
    assign sum = {1'b0, run_time_reg} + {{(RT_W + 1 - EL_W){1'b0}}, cmd.elapsed};

    always_comb
    begin
        run_time_next = run_time_reg;
        running_next  = running_reg;
        if (cmd.tick && sel_me && running_reg)
        begin
            run_time_next = sum[RT_W] ? {RT_W{1'b1}} : sum[RT_W-1:0];
        end
        if (cmd.set_run && sel_me)
        begin
            running_next = 1'b1;
        end
        else if (cmd.clr_run && sel_me)
        begin
            running_next = 1'b0;
        end
    end

    always_comb
    begin
        scan_next = scan_in;
        // strict less keeps the lowest index on a tie
        if (hd && (!scan_in.duty_found || run_time_reg < scan_in.duty_min))
        begin
            scan_next.duty_found = 1'b1;
            scan_next.duty_idx   = idx;
            scan_next.duty_min   = run_time_reg;
        end
        if (hd && after_start && !scan_in.hi_found)
        begin
            scan_next.hi_found = 1'b1;
            scan_next.hi_idx   = idx;
        end
        if (hd && !after_start && !scan_in.lo_found)
        begin
            scan_next.lo_found = 1'b1;
            scan_next.lo_idx   = idx;
        end
        if (hs && !scan_in.sb_found)
        begin
            scan_next.sb_found = 1'b1;
            scan_next.sb_idx   = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_time_reg <= '0;
            running_reg  <= 1'b0;
        end
        else
        begin
            run_time_reg <= run_time_next;
            running_reg  <= running_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    assign scan_out = scan_reg;
    assign running  = running_reg;

endmodule

`default_nettype wire

/* rtl/duty_standby_unit_rotation_top.sv */
// Top level of the blower duty/standby rotation block: stream ports, config, control.
// Depends on dsur_pkg and dsur_cell.
`default_nettype none

// Picks which blower unit runs and keeps per-unit run time (ms, 40 bits, saturating)
// and run flags. Each input beat gives exactly one result beat reflecting the state
// after the command. Items are handled one at a time. A tick or stop goes from accept
// through the execute state to the report state. A start walks a selection packet down
// the row of unit cells, one cell per cycle, before the pick; in rotation mode with a
// unit active the wrapped active position is first settled by repeated subtraction of
// the unit count.
// Config writes are always taken; write only when idle.
module duty_standby_unit_rotation_top #(
    parameter int unsigned MAX_UNITS = dsur_pkg::MAX_UNITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [dsur_pkg::S_DATA_W-1:0]     s_tdata,   // op[1:0], elapsed_ms[17:2]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // active_valid[0], active_index[3:1], active_running[4], no_unit_error[5],
    // station_fail[6]
    output logic [dsur_pkg::M_DATA_W-1:0]          m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dsur_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dsur_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dsur_pkg::*;

    localparam int unsigned CW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_MOD    = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_PICK   = 3'd4;
    localparam logic [2:0] ST_REPORT = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic              rot_mode_reg;
    logic [UCNT_W-1:0] unit_count_reg;
    logic [MASK_W-1:0] duty_mask_reg;
    logic [MASK_W-1:0] fault_mask_reg;
    logic [OP_W-1:0]   op_reg;
    logic [EL_W-1:0]   elapsed_reg;
    logic [IDX_W-1:0]  active_reg, active_next;
    logic              present_reg, present_next;
    logic              err_reg, err_next;
    logic [CNT_W-1:0]  start_reg, start_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic [CNT_W-1:0]  n_units;
    cell_cfg_t         cell_cfg;
    cell_cmd_t         cell_cmd;
    scan_t             chain [MAX_UNITS+1];
    logic [MAX_UNITS-1:0] running_vec;
    logic              found;
    logic [IDX_W-1:0]  pick;
    logic              hd0;
    logic              act_running;
    logic              station_fail;
    logic              out_free;

    assign n_units = ({1'b0, unit_count_reg} > CNT_W'(MAX_UNITS)) ? CNT_W'(MAX_UNITS)
                                                                  : {1'b0, unit_count_reg};

    assign cell_cfg.n_units    = n_units;
    assign cell_cfg.duty_mask  = duty_mask_reg;
    assign cell_cfg.fault_mask = fault_mask_reg;
    assign cell_cfg.rot_start  = start_reg;

    assign chain[0] = '0;

    for (genvar gi = 0; gi < MAX_UNITS; gi++)
    begin : g_cell
        dsur_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (IDX_W'(gi)),
            .cfg      (cell_cfg),
            .cmd      (cell_cmd),
            .scan_in  (chain[gi]),
            .scan_out (chain[gi+1]),
            .running  (running_vec[gi])
        );
    end

    assign hd0 = (n_units != '0) && duty_mask_reg[0] && !fault_mask_reg[0];

    // final pick from the last cell of the chain
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        if (!rot_mode_reg)
        begin
            found = chain[MAX_UNITS].duty_found;
            pick  = chain[MAX_UNITS].duty_idx;
        end
        else if (n_units != '0)
        begin
            if (!present_reg)
            begin
                found = hd0;
            end
            else if (chain[MAX_UNITS].hi_found)
            begin
                found = 1'b1;
                pick  = chain[MAX_UNITS].hi_idx;
            end
            else if (chain[MAX_UNITS].lo_found)
            begin
                found = 1'b1;
                pick  = chain[MAX_UNITS].lo_idx;
            end
        end
        if (!found && chain[MAX_UNITS].sb_found)
        begin
            found = 1'b1;
            pick  = chain[MAX_UNITS].sb_idx;
        end
    end

    always_comb
    begin
        act_running = 1'b0;
        for (int i = 0; i < MAX_UNITS; i++)
        begin
            if (active_reg == IDX_W'(i))
            begin
                act_running = running_vec[i];
            end
        end
        act_running = act_running && present_reg;
    end

    always_comb
    begin
        station_fail = 1'b1;
        for (int i = 0; i < MAX_UNITS; i++)
        begin
            if (CNT_W'(i) < n_units && !(i < MASK_W && fault_mask_reg[i % MASK_W]))
            begin
                station_fail = 1'b0;
            end
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        present_next = present_reg;
        err_next     = err_reg;
        start_next   = start_reg;
        cnt_next     = cnt_reg;
        cell_cmd.tick    = 1'b0;
        cell_cmd.set_run = 1'b0;
        cell_cmd.clr_run = 1'b0;
        cell_cmd.sel     = active_reg;
        cell_cmd.elapsed = elapsed_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    err_next   = 1'b0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_REPORT;
                case (op_reg)
                    OP_TICK:
                    begin
                        cell_cmd.tick = present_reg;
                    end
                    OP_START:
                    begin
                        cnt_next   = '0;
                        start_next = '0;
                        if (rot_mode_reg && present_reg && n_units != '0)
                        begin
                            start_next = {1'b0, active_reg} + CNT_W'(1);
                            state_next = ST_MOD;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    OP_STOP:
                    begin
                        if (present_reg)
                        begin
                            cell_cmd.clr_run = 1'b1;
                            active_next      = '0;
                            present_next     = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_MOD:
            begin
                // wrap (active + 1) into the present unit range
                if (start_reg >= n_units)
                begin
                    start_next = start_reg - n_units;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MAX_UNITS - 1))
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                state_next = ST_REPORT;
                if (found)
                begin
                    cell_cmd.set_run = 1'b1;
                    cell_cmd.sel     = pick;
                    active_next      = pick;
                    present_next     = 1'b1;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rot_mode_reg   <= 1'b0;
            unit_count_reg <= UNIT_COUNT_RST;
            duty_mask_reg  <= DUTY_MASK_RST;
            fault_mask_reg <= FAULT_MASK_RST;
            active_reg     <= '0;
            present_reg    <= 1'b0;
            err_reg        <= 1'b0;
            start_reg      <= '0;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            present_reg <= present_next;
            err_reg     <= err_next;
            start_reg   <= start_next;
            cnt_reg     <= cnt_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_ROTATION_MODE: rot_mode_reg   <= cfg_data[0];
                    REG_UNIT_COUNT:    unit_count_reg <= cfg_data[UCNT_W-1:0];
                    REG_DUTY_MASK:     duty_mask_reg  <= cfg_data[MASK_W-1:0];
                    REG_FAULT_MASK:    fault_mask_reg <= cfg_data[MASK_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == ST_REPORT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            op_reg      <= s_tdata[OP_W-1:0];
            elapsed_reg <= s_tdata[OP_W +: EL_W];
        end
        if (state_reg == ST_REPORT && out_free)
        begin
            m_tdata_reg <= {1'b0, station_fail, err_reg, act_running,
                            present_reg ? active_reg[AIDX_W-1:0] : {AIDX_W{1'b0}},
                            present_reg};
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for duty_standby_unit_rotation_top: drives command beats and register writes,
// predicts every status beat and compares it field by field.
// Depends on dsur_pkg and duty_standby_unit_rotation_top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dsur_pkg::*;

    localparam int NUM_UNITS = MAX_UNITS_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [RT_W-1:0] RUN_TIME_SAT = '1;

    // status beat, lowest bit last
    typedef struct packed {
        logic              station_fail;
        logic              no_unit_error;
        logic              active_running;
        logic [AIDX_W-1:0] active_index;
        logic              active_valid;
    } status_t;

    class station_tracker;
        logic              rotate;
        logic [UCNT_W-1:0] count_reg;
        logic [MASK_W-1:0] duty_bits;
        logic [MASK_W-1:0] fault_bits;
        logic [RT_W-1:0]   hours_ms [NUM_UNITS];
        logic              run_flag [NUM_UNITS];
        int unsigned       lead_unit;
        logic              lead_set;
        status_t           expected_status [$];
        int                mismatches;

        function new();
            rotate = 1'b0;
            count_reg = UNIT_COUNT_RST;
            duty_bits = DUTY_MASK_RST;
            fault_bits = FAULT_MASK_RST;
            foreach (hours_ms[i])
            begin
                hours_ms[i] = '0;
                run_flag[i] = 1'b0;
            end
            lead_unit = 0;
            lead_set = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_ROTATION_MODE: rotate = value[0];
                REG_UNIT_COUNT:    count_reg = value[UCNT_W-1:0];
                REG_DUTY_MASK:     duty_bits = value;
                REG_FAULT_MASK:    fault_bits = value;
                default: ;
            endcase
        endfunction

        function int unsigned station_size();
            return (count_reg > NUM_UNITS) ? NUM_UNITS : count_reg;
        endfunction

        function bit duty_ok(int unsigned i);
            return i < MASK_W && duty_bits[i] && !fault_bits[i];
        endfunction

        function bit standby_ok(int unsigned i);
            return i >= MASK_W || (!duty_bits[i] && !fault_bits[i]);
        endfunction

        function bit pick_unit(output int unsigned pick);
            int unsigned n;
            int unsigned idx;
            bit found;
            logic [RT_W-1:0] least;
            n = station_size();
            found = 1'b0;
            least = '0;
            pick = 0;
            if (!rotate)
            begin
                // least run time, lowest index wins a tie
                for (int i = 0; i < n; i++)
                    if (duty_ok(i) && (!found || hours_ms[i] < least))
                    begin
                        least = hours_ms[i];
                        pick = i;
                        found = 1'b1;
                    end
            end
            else if (n > 0)
            begin
                if (!lead_set)
                begin
                    if (duty_ok(0))
                    begin
                        pick = 0;
                        found = 1'b1;
                    end
                end
                else
                begin
                    for (int k = 1; k <= n && !found; k++)
                    begin
                        idx = (lead_unit + k) % n;
                        if (duty_ok(idx))
                        begin
                            pick = idx;
                            found = 1'b1;
                        end
                    end
                end
            end
            for (int i = 0; i < n && !found; i++)
                if (standby_ok(i))
                begin
                    pick = i;
                    found = 1'b1;
                end
            return found;
        endfunction

        function void note_command(logic [OP_W-1:0] op, logic [EL_W-1:0] elapsed);
            status_t status;
            int unsigned pick;
            int unsigned n;
            logic [RT_W:0] sum;
            logic [MASK_W-1:0] present_mask;
            status = '0;
            case (op)
                OP_TICK:
                    if (lead_set && run_flag[lead_unit])
                    begin
                        sum = {1'b0, hours_ms[lead_unit]} + (RT_W + 1)'(elapsed);
                        hours_ms[lead_unit] = sum[RT_W] ? RUN_TIME_SAT : sum[RT_W-1:0];
                    end
                OP_START:
                    if (pick_unit(pick))
                    begin
                        run_flag[pick] = 1'b1;
                        lead_unit = pick;
                        lead_set = 1'b1;
                    end
                    else
                        status.no_unit_error = 1'b1;
                OP_STOP:
                    if (lead_set)
                    begin
                        run_flag[lead_unit] = 1'b0;
                        lead_unit = 0;
                        lead_set = 1'b0;
                    end
                default: ;
            endcase
            n = station_size();
            present_mask = '0;
            for (int i = 0; i < n; i++)
                present_mask[i] = 1'b1;
            status.active_valid = lead_set;
            status.active_index = lead_set ? AIDX_W'(lead_unit) : '0;
            status.active_running = lead_set && run_flag[lead_unit];
            status.station_fail = (fault_bits & present_mask) == present_mask;
            expected_status = {expected_status, status};
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        task report_mismatch(string field, int got, int want);
            mismatches++;
            $display("[%0t] status %s: got %0d, expected %0d", $time, field, got, want);
        endtask

        task check_status(logic [M_DATA_W-1:0] beat);
            status_t got;
            status_t want;
            got = status_t'(beat[$bits(status_t)-1:0]);
            if (expected_status.size() == 0)
            begin
                report_mismatch("beat with nothing pending", beat, 0);
                return;
            end
            want = expected_status.pop_front();
            if (got.active_valid !== want.active_valid)
                report_mismatch("active_valid", got.active_valid, want.active_valid);
            if (got.active_index !== want.active_index)
                report_mismatch("active_index", got.active_index, want.active_index);
            if (got.active_running !== want.active_running)
                report_mismatch("active_running", got.active_running, want.active_running);
            if (got.no_unit_error !== want.no_unit_error)
                report_mismatch("no_unit_error", got.no_unit_error, want.no_unit_error);
            if (got.station_fail !== want.station_fail)
                report_mismatch("station_fail", got.station_fail, want.station_fail);
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    station_tracker station;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    duty_standby_unit_rotation_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            station.check_status(m_tdata);

    task automatic send_command(logic [OP_W-1:0] op, logic [EL_W-1:0] elapsed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata <= S_DATA_W'($urandom);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= S_DATA_W'({elapsed, op});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        station.note_command(op, elapsed);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (station.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        station.write_reg(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random();
        int r;
        logic [EL_W-1:0] elapsed;
        logic [OP_W-1:0] op;
        r = $urandom_range(99);
        case ($urandom_range(9))
            0:       elapsed = '0;
            1:       elapsed = '1;
            default: elapsed = EL_W'($urandom);
        endcase
        if (r < 50)
            op = OP_TICK;
        else if (r < 75)
            op = OP_START;
        else if (r < 95)
            op = OP_STOP;
        else
            op = OP_UNUSED;
        send_command(op, elapsed);
    endtask

    task automatic configure_random();
        int r;
        logic [CFG_DATA_W-1:0] value;
        write_reg(REG_ROTATION_MODE, CFG_DATA_W'($urandom_range(1)));
        r = $urandom_range(19);
        if (r == 0)
            value = '0;
        else if (r == 1)
            value = CFG_DATA_W'($urandom_range(15, 9));
        else
            value = CFG_DATA_W'($urandom_range(NUM_UNITS, 1));
        write_reg(REG_UNIT_COUNT, value);
        r = $urandom_range(7);
        value = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : CFG_DATA_W'($urandom);
        write_reg(REG_DUTY_MASK, value);
        // faults kept sparse so most starts find a unit
        r = $urandom_range(9);
        if (r == 0)
            value = 8'hFF;
        else if (r < 4)
            value = 8'h00;
        else
            value = CFG_DATA_W'($urandom & $urandom & $urandom);
        write_reg(REG_FAULT_MASK, value);
    endtask

    task automatic run_directed();
        // reset settings: two units, unit 0 duty
        send_command(OP_TICK, '0);
        send_command(OP_STOP, '0);
        send_command(OP_UNUSED, '1);
        send_command(OP_START, '0);
        send_command(OP_TICK, '1);
        send_command(OP_START, '1);
        send_command(OP_STOP, '0);
        // four duty units: tie on least run time, start while active
        write_reg(REG_UNIT_COUNT, 8'd4);
        write_reg(REG_DUTY_MASK, 8'h0F);
        send_command(OP_START, '0);
        send_command(OP_TICK, 16'h5555);
        send_command(OP_START, 16'hAAAA);
        send_command(OP_STOP, '0);
        // rotation from no active unit, then wrap past the last unit
        write_reg(REG_ROTATION_MODE, 8'd1);
        repeat (5)
            send_command(OP_START, '0);
        send_command(OP_STOP, '0);
        // unit 0 failed, no standby: start fails; then standby fallback
        write_reg(REG_FAULT_MASK, 8'h01);
        send_command(OP_START, '0);
        write_reg(REG_DUTY_MASK, 8'h0C);
        send_command(OP_START, '0);
        write_reg(REG_FAULT_MASK, 8'hFF);
        send_command(OP_START, '0);
        write_reg(REG_FAULT_MASK, 8'h00);
        write_reg(REG_UNIT_COUNT, 8'd0);
        send_command(OP_START, '0);
        // count above the limit, then active unit left beyond a reduced count
        write_reg(REG_UNIT_COUNT, 8'd15);
        write_reg(REG_DUTY_MASK, 8'h80);
        write_reg(REG_ROTATION_MODE, 8'd0);
        send_command(OP_START, '0);
        write_reg(REG_UNIT_COUNT, 8'd3);
        send_command(OP_TICK, 16'h1234);
        write_reg(REG_DUTY_MASK, 8'h81);
        write_reg(REG_ROTATION_MODE, 8'd1);
        send_command(OP_START, '0);
        send_command(OP_STOP, '0);
    endtask

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        station = new();
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int seg = 0; seg < 6; seg++)
            begin
                configure_random();
                for (int j = 0; j < 60; j++)
                begin
                    // block fills up and backs up the input
                    if (phase == 0 && seg == 2 && j == 10)
                        hold_req = 1'b1;
                    if (phase == 2 && seg == 3 && j == 30)
                        wait_drained();
                    send_random();
                end
            end
        end
        wait_drained();
        repeat (40)
            @(posedge clk);
        if (station.mismatches == 0 && station.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
